// ----- src/nfa_pkg.sv -----
`default_nettype none

package nfa_pkg;

	// array geometry defaults
	localparam int MAX_BLOCKS_DEF      = 16;
	localparam int PAGES_PER_BLOCK_DEF = 64;
	localparam int PAGE_BYTES_DEF      = 512;
	localparam int SPARE_BYTES_DEF     = 16;

	// field widths
	localparam int CMD_W    = 2;
	localparam int BLOCK_W  = 4;
	localparam int PAGE_W   = 6;
	localparam int COL_W    = 10;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 5;

	// input word layout
	localparam int CMD_LSB   = 0;
	localparam int BLOCK_LSB = CMD_LSB + CMD_W;
	localparam int PAGE_LSB  = BLOCK_LSB + BLOCK_W;
	localparam int COL_LSB   = PAGE_LSB + PAGE_W;
	localparam int DATA_LSB  = COL_LSB + COL_W;
	localparam int S_TDATA_W = 32;

	// output word layout
	localparam int M_TDATA_W = 16;

	localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_ERASE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ADDR  = 2'd1,
		ST_WRITE_ERR = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ----- src/nfa_ram.sv -----
`default_nettype none

module nfa_ram #(
	parameter int WIDTH = 8,
	parameter longint DEPTH = 2,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire               clk,
	input  wire               we,
	input  wire  [ADDR_W-1:0] waddr,
	input  wire  [WIDTH-1:0]  wdata,
	input  wire               re,
	input  wire  [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- src/nfa_madd.sv -----
`default_nettype none

module nfa_madd #(
	parameter int A_W = 20,
	parameter int B_W = 10,
	parameter int C_W = 10,
	parameter int R_W = 20,
	localparam int P_W = A_W + B_W
) (
	input  wire              clk,
	input  wire              en,
	input  wire  [A_W-1:0]   a,
	input  wire  [B_W-1:0]   b,
	input  wire  [C_W-1:0]   c,
	output logic [R_W-1:0]   result
);

	logic [P_W-1:0] prod;
	logic [R_W-1:0] result_q;

	// shared multiply-add, result registered
	assign prod = P_W'(a) * P_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= R_W'(prod) + R_W'(c);
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

// ----- src/nand_flash_array_model.sv -----
// byte read, erase of a bad block: via the address, dispatch and response states
// program load without last, unused command: straight from accept to the response state
// page commit: check and apply pass of ROW = PAGE_BYTES+SPARE_BYTES; no check on bad address
// block erase: the block is written to 0xff, one byte per cycle; result waits on m_tready
// one word at a time; s_tready is high only while the sequencer is idle
// after arst_n the array is swept to 0xff, one byte per cycle
`default_nettype none

module nand_flash_array_model #(
	parameter int MAX_BLOCKS      = nfa_pkg::MAX_BLOCKS_DEF,
	parameter int PAGES_PER_BLOCK = nfa_pkg::PAGES_PER_BLOCK_DEF,
	parameter int PAGE_BYTES      = nfa_pkg::PAGE_BYTES_DEF,
	parameter int SPARE_BYTES     = nfa_pkg::SPARE_BYTES_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration: block_count
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [nfa_pkg::CFG_W-1:0]     cfg_data,
	// cmd, block, page, column, data_byte from bit 0 up, zero pad
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [nfa_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire                           s_tlast,
	// read_data, status from bit 0 up, zero pad
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [nfa_pkg::M_TDATA_W-1:0] m_tdata
);

	import nfa_pkg::*;

	localparam int     ROW_BYTES   = PAGE_BYTES + SPARE_BYTES;
	localparam longint BLOCK_BYTES = longint'(PAGES_PER_BLOCK) * longint'(ROW_BYTES);
	localparam longint ARRAY_BYTES = longint'(MAX_BLOCKS) * BLOCK_BYTES;
	localparam int     ADDR_W      = (ARRAY_BYTES > 1) ? $clog2(ARRAY_BYTES) : 1;
	localparam int     COLI_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int     CNT_W       = $clog2(ARRAY_BYTES + 1);
	localparam int     MUL_MAX     = (PAGES_PER_BLOCK > ROW_BYTES) ? PAGES_PER_BLOCK : ROW_BYTES;
	localparam int     MUL_W       = $clog2(MUL_MAX + 1);
	localparam int     PBUF_W      = DATA_W + 1;

	typedef enum logic [7:0] {
		S_CLEAR    = 8'b0000_0001,
		S_IDLE     = 8'b0000_0010,
		S_ADDR     = 8'b0000_0100,
		S_DISPATCH = 8'b0000_1000,
		S_ERASE    = 8'b0001_0000,
		S_CHECK    = 8'b0010_0000,
		S_APPLY    = 8'b0100_0000,
		S_RESP     = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 walk_v_s1;
	logic                 err_q;
	logic                 m_tvalid_q;
	logic [CFG_W-1:0]     block_count_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [COL_W-1:0]     col_q;
	logic                 ok_q;
	logic                 rd_hit_q;
	status_t              status_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    waddr_s1;
	logic [COLI_W-1:0]    bidx_s1;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [CMD_W-1:0]     in_cmd;
	logic [BLOCK_W-1:0]   in_blk;
	logic [PAGE_W-1:0]    in_pg;
	logic [COL_W-1:0]     in_col;
	logic [DATA_W-1:0]    in_dat;
	logic                 in_fire;
	logic                 blk_ok;
	logic                 pg_ok;
	logic                 col_ok;
	logic                 addr_ok;
	logic                 walk_issue;
	logic                 push;

	logic                 madd_en;
	logic [ADDR_W-1:0]    madd_a;
	logic [MUL_W-1:0]     madd_b;
	logic [COL_W-1:0]     madd_c;
	logic [ADDR_W-1:0]    madd_result;

	logic                 arr_we;
	logic [ADDR_W-1:0]    arr_waddr;
	logic [DATA_W-1:0]    arr_wdata;
	logic                 arr_re;
	logic [ADDR_W-1:0]    arr_raddr;
	logic [DATA_W-1:0]    arr_rdata;

	logic                 pbuf_we;
	logic [COLI_W-1:0]    pbuf_waddr;
	logic [PBUF_W-1:0]    pbuf_wdata;
	logic                 pbuf_re;
	logic [COLI_W-1:0]    pbuf_raddr;
	logic [PBUF_W-1:0]    pbuf_rdata;

	// input word fields
	assign in_cmd = s_tdata[CMD_LSB +: CMD_W];
	assign in_blk = s_tdata[BLOCK_LSB +: BLOCK_W];
	assign in_pg  = s_tdata[PAGE_LSB +: PAGE_W];
	assign in_col = s_tdata[COL_LSB +: COL_W];
	assign in_dat = s_tdata[DATA_LSB +: DATA_W];

	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// address range checks
	assign blk_ok  = (CFG_W'(in_blk) < block_count_q) && (int'(in_blk) < MAX_BLOCKS);
	assign pg_ok   = int'(in_pg) < PAGES_PER_BLOCK;
	assign col_ok  = int'(in_col) < ROW_BYTES;
	assign addr_ok = blk_ok && pg_ok && col_ok;

	assign walk_issue = cnt_q < CNT_W'(ROW_BYTES);
	assign push       = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	// operand select: row index on accept, byte address in the next cycle from the address state
	// erase starts at the first page of the block
	always_comb begin
		madd_en = (state_q == S_ADDR) || in_fire;
		if (state_q == S_ADDR) begin
			madd_a = madd_result;
			madd_b = MUL_W'(ROW_BYTES);
			madd_c = (cmd_q == CMD_READ) ? col_q : '0;
		end else begin
			madd_a = ADDR_W'(in_blk);
			madd_b = MUL_W'(PAGES_PER_BLOCK);
			madd_c = (in_cmd == CMD_ERASE) ? '0 : COL_W'(in_pg);
		end
	end

	nfa_madd #(
		.A_W (ADDR_W),
		.B_W (MUL_W),
		.C_W (COL_W),
		.R_W (ADDR_W)
	) u_madd (
		.clk    (clk),
		.en     (madd_en),
		.a      (madd_a),
		.b      (madd_b),
		.c      (madd_c),
		.result (madd_result)
	);

	// memory port control per state
	always_comb begin
		arr_we     = 1'b0;
		arr_waddr  = addr_q;
		arr_wdata  = '1;
		arr_re     = 1'b0;
		arr_raddr  = addr_q;
		pbuf_we    = 1'b0;
		pbuf_waddr = bidx_s1;
		pbuf_wdata = '0;
		pbuf_re    = 1'b0;
		pbuf_raddr = cnt_q[COLI_W-1:0];
		case (state_q)
			S_CLEAR: begin
				arr_we     = 1'b1;
				arr_waddr  = cnt_q[ADDR_W-1:0];
				pbuf_we    = cnt_q < CNT_W'(ROW_BYTES);
				pbuf_waddr = cnt_q[COLI_W-1:0];
			end
			S_IDLE: begin
				pbuf_we    = in_fire && (in_cmd == CMD_LOAD) && col_ok;
				pbuf_waddr = COLI_W'(in_col);
				pbuf_wdata = {1'b1, in_dat};
			end
			S_DISPATCH: begin
				arr_re    = rd_hit_q;
				arr_raddr = madd_result;
			end
			S_ERASE: begin
				arr_we = 1'b1;
			end
			S_CHECK: begin
				arr_re  = walk_issue;
				pbuf_re = walk_issue;
			end
			S_APPLY: begin
				arr_re    = walk_issue;
				pbuf_re   = walk_issue;
				pbuf_we   = walk_v_s1;
				arr_we    = walk_v_s1 && ok_q && !err_q && pbuf_rdata[DATA_W];
				arr_waddr = waddr_s1;
				arr_wdata = arr_rdata & pbuf_rdata[DATA_W-1:0];
			end
			default: begin
				arr_we = 1'b0;
			end
		endcase
	end

	nfa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (ARRAY_BYTES)
	) u_arr_ram (
		.clk   (clk),
		.we    (arr_we),
		.waddr (arr_waddr),
		.wdata (arr_wdata),
		.re    (arr_re),
		.raddr (arr_raddr),
		.rdata (arr_rdata)
	);

	// page buffer with loaded mark in the top bit
	nfa_ram #(
		.WIDTH (PBUF_W),
		.DEPTH (longint'(ROW_BYTES))
	) u_pbuf_ram (
		.clk   (clk),
		.we    (pbuf_we),
		.waddr (pbuf_waddr),
		.wdata (pbuf_wdata),
		.re    (pbuf_re),
		.raddr (pbuf_raddr),
		.rdata (pbuf_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			cnt_q         <= '0;
			walk_v_s1     <= 1'b0;
			err_q         <= 1'b0;
			m_tvalid_q    <= 1'b0;
			block_count_q <= BLOCK_COUNT_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				block_count_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready && !push) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(ARRAY_BYTES - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						err_q <= 1'b0;
						cnt_q <= '0;
						case (in_cmd)
							CMD_READ, CMD_ERASE: state_q <= S_ADDR;
							CMD_LOAD: state_q <= s_tlast ? S_ADDR : S_RESP;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_ADDR: begin
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					cnt_q <= '0;
					case (cmd_q)
						CMD_ERASE: state_q <= ok_q ? S_ERASE : S_RESP;
						CMD_LOAD: state_q <= ok_q ? S_CHECK : S_APPLY;
						default: state_q <= S_RESP;
					endcase
				end
				S_ERASE: begin
					if (cnt_q == CNT_W'(BLOCK_BYTES - 1)) begin
						state_q <= S_RESP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CHECK: begin
					walk_v_s1 <= walk_issue;
					// a loaded byte may only clear bits
					if (walk_v_s1 && pbuf_rdata[DATA_W] &&
						((arr_rdata & pbuf_rdata[DATA_W-1:0]) != pbuf_rdata[DATA_W-1:0])) begin
						err_q <= 1'b1;
					end
					if (walk_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q   <= '0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					walk_v_s1 <= walk_issue;
					if (walk_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (push) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload, walk address and result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd_q    <= in_cmd;
					col_q    <= in_col;
					rd_hit_q <= (in_cmd == CMD_READ) && addr_ok;
					ok_q     <= (in_cmd == CMD_ERASE) ? blk_ok : addr_ok;
					case (in_cmd)
						CMD_READ: status_q <= addr_ok ? ST_OK : ST_BAD_ADDR;
						CMD_LOAD: begin
							if (s_tlast) begin
								status_q <= addr_ok ? ST_OK : ST_BAD_ADDR;
							end else begin
								status_q <= col_ok ? ST_OK : ST_BAD_ADDR;
							end
						end
						CMD_ERASE: status_q <= blk_ok ? ST_OK : ST_BAD_ADDR;
						default: status_q <= ST_OK;
					endcase
				end
			end
			S_DISPATCH: begin
				addr_q <= madd_result;
			end
			S_ERASE: begin
				addr_q <= addr_q + 1'b1;
			end
			S_CHECK: begin
				// rewind to the page base for the apply pass
				if (walk_issue) begin
					addr_q <= addr_q + 1'b1;
				end else begin
					addr_q <= madd_result;
				end
			end
			S_APPLY: begin
				waddr_s1 <= addr_q;
				bidx_s1  <= cnt_q[COLI_W-1:0];
				if (walk_issue) begin
					addr_q <= addr_q + 1'b1;
				end else if (ok_q && err_q) begin
					status_q <= ST_WRITE_ERR;
				end
			end
			S_RESP: begin
				if (push) begin
					m_tdata_q <= M_TDATA_W'({status_q, (rd_hit_q ? arr_rdata : DATA_W'(0))});
				end
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

	// a result word is only produced by the response state
	a_push_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == S_RESP)
		else $error("result word raised outside response state");

	// the array is never written while new words are taken
	a_idle_no_array_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !arr_we)
		else $error("array write while idle");

	// the walk pipeline is drained before the next word
	a_idle_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !walk_v_s1)
		else $error("walk stage still valid in idle");

	// a failed check leaves the page untouched
	a_err_blocks_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && err_q) |-> !arr_we)
		else $error("page written after program check failed");

endmodule

`default_nettype wire
